// ===== hw/rtl/wlcs_pkg.sv =====
// Shared types and constants for the word-length counting sort block.
// No dependencies; used by all RTL files under hw/rtl except wlcs_stream_if.
`timescale 1ns / 1ps

package wlcs_pkg;

  // The only word separator.
  localparam logic [7:0] SpaceCode = 8'd32;

  // Status of a sequenced unit (ranker, emitter).
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hw/rtl/wlcs_stream_if.sv =====
// Valid/ready stream interfaces for the input and output words.
// No dependencies.
`timescale 1ns / 1ps

interface wlcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_valid;
  logic       end_of_text;

  modport source (output valid, char_code, char_valid, end_of_text, input ready);
  modport sink   (input valid, char_code, char_valid, end_of_text, output ready);
endinterface

interface wlcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  logic       truncated;

  modport source (output valid, out_char, last_char, truncated, input ready);
  modport sink   (input valid, out_char, last_char, truncated, output ready);
endinterface

// ===== hw/rtl/wlcs_text_store.sv =====
// Character memory, fill counter and on-the-fly word boundary tracking.
// Depends on wlcs_pkg.
`timescale 1ns / 1ps

module wlcs_text_store #(
  parameter int MAX_CHARS = 64,
  parameter int MAX_WORDS = 32,
  localparam int AW  = $clog2(MAX_CHARS),
  localparam int CW  = $clog2(MAX_CHARS + 1),
  localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int NW  = $clog2(MAX_WORDS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     char_code_i,
  input  logic           char_valid_i,
  input  logic           end_i,
  output logic           wr_en_o,
  output logic [WIW-1:0] wr_addr_o,
  output logic [AW-1:0]  wr_start_o,
  output logic [CW-1:0]  wr_len_o,
  output logic [NW-1:0]  total_o,
  output logic           ovf_o,
  input  logic [AW-1:0]  rd_addr_i,
  output logic [7:0]     rd_data_o
);

  logic [7:0]    char_mem [MAX_CHARS];
  logic [7:0]    rd_data_q;
  logic [CW-1:0] fill_q;
  logic          in_word_q;
  logic [AW-1:0] wstart_q;
  logic [NW-1:0] wcnt_q;
  logic          ovf_q;

  logic          store, is_space, in_after, open_now, close_now, room;
  logic [AW-1:0] start;
  logic [CW-1:0] end_pos;
  logic [NW-1:0] wcnt_nx;
  logic          ovf_nx;

  always_comb begin
    store     = acc_i && char_valid_i && (fill_q < CW'(MAX_CHARS));
    is_space  = (char_code_i == wlcs_pkg::SpaceCode);
    in_after  = store ? !is_space : in_word_q;
    open_now  = store && !is_space && !in_word_q;
    start     = open_now ? fill_q[AW-1:0] : wstart_q;
    end_pos   = fill_q + CW'(store && !is_space);
    close_now = acc_i && ((store && is_space && in_word_q) || (end_i && in_after));
    room      = (wcnt_q < NW'(MAX_WORDS));
    wr_en_o    = close_now && room;
    wr_addr_o  = wcnt_q[WIW-1:0];
    wr_start_o = start;
    wr_len_o   = end_pos - CW'(start);
    wcnt_nx    = wcnt_q + NW'(wr_en_o);
    ovf_nx     = ovf_q || (acc_i && char_valid_i && !store) || (close_now && !room);
  end

  assign total_o   = wcnt_nx;
  assign ovf_o     = ovf_nx;
  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      in_word_q <= 1'b0;
      wcnt_q    <= '0;
      ovf_q     <= 1'b0;
    end else if (acc_i && end_i) begin
      // sentence complete: counters restart for the next one
      fill_q    <= '0;
      in_word_q <= 1'b0;
      wcnt_q    <= '0;
      ovf_q     <= 1'b0;
    end else if (acc_i) begin
      fill_q    <= fill_q + CW'(store);
      in_word_q <= in_after;
      wcnt_q    <= wcnt_nx;
      ovf_q     <= ovf_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (open_now) begin
      wstart_q <= fill_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      char_mem[fill_q[AW-1:0]] <= char_code_i;
    end
    rd_data_q <= char_mem[rd_addr_i];
  end

endmodule

// ===== hw/rtl/wlcs_ranker.sv =====
// Word table (start, length) and rank-ordered index table; comparison
// counting pass over the word lengths. Depends on wlcs_pkg.
`timescale 1ns / 1ps

module wlcs_ranker #(
  parameter int MAX_CHARS = 64,
  parameter int MAX_WORDS = 32,
  localparam int AW  = $clog2(MAX_CHARS),
  localparam int CW  = $clog2(MAX_CHARS + 1),
  localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int NW  = $clog2(MAX_WORDS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [WIW-1:0]       wr_addr_i,
  input  logic [AW-1:0]        wr_start_i,
  input  logic [CW-1:0]        wr_len_i,
  input  logic                 start_i,
  input  logic [NW-1:0]        total_i,
  output wlcs_pkg::unit_stat_t stat_o,
  input  logic [WIW-1:0]       ord_addr_i,
  output logic [WIW-1:0]       ord_data_o,
  input  logic [WIW-1:0]       wrd_addr_i,
  output logic [AW-1:0]        wrd_start_o,
  output logic [CW-1:0]        wrd_len_o
);

  localparam logic [1:0] RkIdle  = 2'd0;
  localparam logic [1:0] RkIssue = 2'd1;
  localparam logic [1:0] RkDrain = 2'd2;

  logic [CW-1:0]  len_mem   [MAX_WORDS];
  logic [AW-1:0]  start_mem [MAX_WORDS];
  logic [WIW-1:0] order_mem [MAX_WORDS];

  logic [1:0]     state_q;
  logic [WIW-1:0] a_q, b_q, nm1_q, pb_q, cnt_q;
  logic           p1_q, plast_q;
  logic [CW-1:0]  lena_q, lenb_q;
  logic [AW-1:0]  starta_q;
  logic [WIW-1:0] ord_q;

  logic [WIW-1:0] a_addr;
  logic           ahead;
  logic [WIW-1:0] rank_sum;
  logic           ord_we;

  assign stat_o.busy = (state_q != RkIdle);
  assign stat_o.done = (state_q == RkDrain) && (a_q == nm1_q);
  assign a_addr      = stat_o.busy ? a_q : wrd_addr_i;

  // word b ranks ahead of word a: shorter, or same length and earlier
  assign ahead    = (lenb_q < lena_q) || ((lenb_q == lena_q) && (pb_q < a_q));
  assign rank_sum = cnt_q + WIW'(ahead);
  assign ord_we   = p1_q && plast_q;

  assign ord_data_o  = ord_q;
  assign wrd_start_o = starta_q;
  assign wrd_len_o   = lena_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      len_mem[wr_addr_i]   <= wr_len_i;
      start_mem[wr_addr_i] <= wr_start_i;
    end
    lena_q   <= len_mem[a_addr];
    starta_q <= start_mem[a_addr];
    lenb_q   <= len_mem[b_q];
    if (ord_we) begin
      order_mem[rank_sum] <= a_q;
    end
    ord_q <= order_mem[ord_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RkIdle;
      a_q     <= '0;
      b_q     <= '0;
      nm1_q   <= '0;
      cnt_q   <= '0;
      p1_q    <= 1'b0;
      pb_q    <= '0;
      plast_q <= 1'b0;
    end else begin
      p1_q    <= (state_q == RkIssue);
      pb_q    <= b_q;
      plast_q <= (b_q == nm1_q);
      if (p1_q) begin
        cnt_q <= plast_q ? '0 : rank_sum;
      end
      case (state_q)
        RkIdle: begin
          if (start_i) begin
            state_q <= RkIssue;
            a_q     <= '0;
            b_q     <= '0;
            nm1_q   <= WIW'(total_i - NW'(1));
          end
        end
        RkIssue: begin
          if (b_q == nm1_q) begin
            b_q     <= '0;
            state_q <= RkDrain;
          end else begin
            b_q <= b_q + WIW'(1);
          end
        end
        RkDrain: begin
          if (a_q == nm1_q) begin
            state_q <= RkIdle;
          end else begin
            a_q     <= a_q + WIW'(1);
            state_q <= RkIssue;
          end
        end
        default: state_q <= RkIdle;
      endcase
    end
  end

endmodule

// ===== hw/rtl/wlcs_emitter.sv =====
// Output sequencer: walks words in rank order, reads their characters and
// feeds the output register. Depends on wlcs_pkg and wlcs_stream_if.
`timescale 1ns / 1ps

module wlcs_emitter #(
  parameter int MAX_CHARS = 64,
  parameter int MAX_WORDS = 32,
  localparam int AW  = $clog2(MAX_CHARS),
  localparam int CW  = $clog2(MAX_CHARS + 1),
  localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int NW  = $clog2(MAX_WORDS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NW-1:0]        total_i,
  input  logic                 trunc_i,
  output wlcs_pkg::unit_stat_t stat_o,
  output logic [WIW-1:0]       ord_addr_o,
  input  logic [WIW-1:0]       ord_data_i,
  output logic [WIW-1:0]       wrd_addr_o,
  input  logic [AW-1:0]        wrd_start_i,
  input  logic [CW-1:0]        wrd_len_i,
  output logic [AW-1:0]        chr_addr_o,
  input  logic [7:0]           chr_data_i,
  wlcs_out_if.source           out_o
);

  localparam logic [2:0] EmIdle = 3'd0;
  localparam logic [2:0] EmOrd  = 3'd1;
  localparam logic [2:0] EmWrd  = 3'd2;
  localparam logic [2:0] EmPos  = 3'd3;
  localparam logic [2:0] EmChr  = 3'd4;
  localparam logic [2:0] EmLoad = 3'd5;
  localparam logic [2:0] EmSpc  = 3'd6;

  logic [2:0]     state_q;
  logic [WIW-1:0] r_q, nm1_q;
  logic           trunc_q;
  logic [AW-1:0]  pos_q;
  logic [CW-1:0]  rem_q;
  logic           ovalid_q;
  logic [7:0]     ochar_q;
  logic           olast_q, otrunc_q;

  logic slot_free, last_now, load_chr, load_spc;

  assign slot_free = !ovalid_q || out_o.ready;
  assign last_now  = (rem_q == CW'(1)) && (r_q == nm1_q);
  assign load_chr  = (state_q == EmLoad) && slot_free;
  assign load_spc  = (state_q == EmSpc) && slot_free;

  assign stat_o.busy = (state_q != EmIdle);
  assign stat_o.done = load_chr && last_now;

  assign ord_addr_o = r_q;
  assign wrd_addr_o = ord_data_i;
  assign chr_addr_o = pos_q;

  assign out_o.valid     = ovalid_q;
  assign out_o.out_char  = ochar_q;
  assign out_o.last_char = olast_q;
  assign out_o.truncated = otrunc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EmIdle;
      ovalid_q <= 1'b0;
    end else begin
      if (load_chr || load_spc) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        EmIdle: if (start_i) state_q <= EmOrd;
        EmOrd:  state_q <= EmWrd;
        EmWrd:  state_q <= EmPos;
        EmPos:  state_q <= EmChr;
        EmChr:  state_q <= EmLoad;
        EmLoad: begin
          if (slot_free) begin
            if (rem_q != CW'(1)) begin
              state_q <= EmChr;
            end else if (r_q == nm1_q) begin
              state_q <= EmIdle;
            end else begin
              state_q <= EmSpc;
            end
          end
        end
        EmSpc: if (slot_free) state_q <= EmOrd;
        default: state_q <= EmIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == EmIdle) && start_i) begin
      r_q     <= '0;
      nm1_q   <= WIW'(total_i - NW'(1));
      trunc_q <= trunc_i;
    end
    if (state_q == EmPos) begin
      pos_q <= wrd_start_i;
      rem_q <= wrd_len_i;
    end
    if (load_chr) begin
      ochar_q  <= chr_data_i;
      olast_q  <= last_now;
      otrunc_q <= trunc_q;
      pos_q    <= pos_q + AW'(1);
      rem_q    <= rem_q - CW'(1);
    end
    if (load_spc) begin
      ochar_q  <= wlcs_pkg::SpaceCode;
      olast_q  <= 1'b0;
      otrunc_q <= trunc_q;
      r_q      <= r_q + WIW'(1);
    end
  end

endmodule

// ===== hw/rtl/word_length_counting_sort.sv =====
// Top level of the word-length counting sort block.
// Depends on wlcs_pkg, wlcs_stream_if, wlcs_text_store, wlcs_ranker, wlcs_emitter.
//
// Usage:
//   in_i  (sink)  : one word per character; char_valid marks a real character,
//                   end_of_text closes the sentence (the character, if any, is
//                   stored first). Accepted when valid && ready.
//   out_o (source): the words of the sentence ordered by length (stable),
//                   one character per word, single spaces between words,
//                   last_char on the final one, truncated when characters or
//                   words were dropped for lack of room.
//   Loading runs at one character per cycle. After the end word ready drops
//   while the word table is ranked, one length compare per cycle through the
//   second table read port. Emission then reads the order memory, the word
//   table and, for each character, the character memory, and loads each
//   character and each separating space into the output register; every one
//   of these memory reads is registered.
//   An empty sentence gives no output and ready stays high.
//   A stalled receiver holds the output register; the sequencer waits and
//   input stays blocked until the last character sits in the output register.
//   Reset (rst_ni low, async) empties the sentence and clears all sequencers;
//   no memory clearing pass is needed.
`timescale 1ns / 1ps

module word_length_counting_sort #(
  parameter int MAX_CHARS = 64,
  parameter int MAX_WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wlcs_in_if.sink     in_i,
  wlcs_out_if.source  out_o
);

  localparam int AW  = $clog2(MAX_CHARS);
  localparam int CW  = $clog2(MAX_CHARS + 1);
  localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int NW  = $clog2(MAX_WORDS + 1);

  logic                 in_acc, end_acc, rk_start;
  logic                 wr_en;
  logic [WIW-1:0]       wr_addr;
  logic [AW-1:0]        wr_start;
  logic [CW-1:0]        wr_len;
  logic [NW-1:0]        ts_total;
  logic                 ts_ovf;
  logic [AW-1:0]        chr_addr;
  logic [7:0]           chr_data;
  wlcs_pkg::unit_stat_t rk_stat, em_stat;
  logic [WIW-1:0]       ord_addr, ord_data, wrd_addr;
  logic [AW-1:0]        wrd_start;
  logic [CW-1:0]        wrd_len;
  logic [NW-1:0]        total_q;
  logic                 trunc_q;

  // input is taken whenever neither the ranker nor the emitter is running
  assign in_i.ready = !rk_stat.busy && !em_stat.busy;
  assign in_acc     = in_i.valid && in_i.ready;
  assign end_acc    = in_acc && in_i.end_of_text;
  assign rk_start   = end_acc && (ts_total != '0);

  // word count and drop flag of the closed sentence, handed to the emitter
  always_ff @(posedge clk_i) begin
    if (rk_start) begin
      total_q <= ts_total;
      trunc_q <= ts_ovf;
    end
  end

  wlcs_text_store #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_WORDS (MAX_WORDS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .char_code_i  (in_i.char_code),
    .char_valid_i (in_i.char_valid),
    .end_i        (in_i.end_of_text),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_start_o   (wr_start),
    .wr_len_o     (wr_len),
    .total_o      (ts_total),
    .ovf_o        (ts_ovf),
    .rd_addr_i    (chr_addr),
    .rd_data_o    (chr_data)
  );

  wlcs_ranker #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_WORDS (MAX_WORDS)
  ) u_ranker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_start_i  (wr_start),
    .wr_len_i    (wr_len),
    .start_i     (rk_start),
    .total_i     (ts_total),
    .stat_o      (rk_stat),
    .ord_addr_i  (ord_addr),
    .ord_data_o  (ord_data),
    .wrd_addr_i  (wrd_addr),
    .wrd_start_o (wrd_start),
    .wrd_len_o   (wrd_len)
  );

  wlcs_emitter #(
    .MAX_CHARS (MAX_CHARS),
    .MAX_WORDS (MAX_WORDS)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rk_stat.done),
    .total_i     (total_q),
    .trunc_i     (trunc_q),
    .stat_o      (em_stat),
    .ord_addr_o  (ord_addr),
    .ord_data_i  (ord_data),
    .wrd_addr_o  (wrd_addr),
    .wrd_start_i (wrd_start),
    .wrd_len_i   (wrd_len),
    .chr_addr_o  (chr_addr),
    .chr_data_i  (chr_data),
    .out_o       (out_o)
  );

endmodule

// ===== hw/rtl/wlcs_checker.sv =====
// Port-level assertions for word_length_counting_sort, attached by bind.
// Depends on wlcs_pkg and word_length_counting_sort.
`timescale 1ns / 1ps

module wlcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       out_last_i,
  input logic       out_trunc_i
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_char_i) && $stable(out_last_i) && $stable(out_trunc_i))
    else $error("output word changed while stalled");

  // mid-sentence output means the emitter still runs, so input is blocked
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready while a sentence is still being emitted");

  // truncated flag is the same across one sentence
  a_trunc_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
      !out_valid_i || (out_trunc_i == $past(out_trunc_i)))
    else $error("truncated flag changed within a sentence");

  // separators never end a sentence
  a_space_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_char_i == wlcs_pkg::SpaceCode) |-> !out_last_i)
    else $error("space marked as last character");

endmodule

bind word_length_counting_sort wlcs_checker u_wlcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.out_char),
  .out_last_i  (out_o.last_char),
  .out_trunc_i (out_o.truncated)
);
